// ===== hw/rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the proximity repetition counter
// Register indexes, register reset values, field widths and bundles that are
// passed between the top level and the counting core.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Field widths
  localparam int DIST_W  = 10;  // input reading
  localparam int LVL_W   = 6;   // clamped reading and 6-bit registers
  localparam int THR_W   = 8;   // thresholds and absence limit
  localparam int COUNT_W = 8;   // visible count
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENCE   = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0] RST_DOWN_THR = 8'd15;
  localparam logic [THR_W-1:0] RST_UP_THR   = 8'd30;
  localparam logic [LVL_W-1:0] RST_MAX_DIST = 6'd50;
  localparam logic [LVL_W-1:0] RST_JUMP_LIM = 6'd10;
  localparam logic [LVL_W-1:0] RST_BOTTOM   = 6'd5;
  localparam logic [THR_W-1:0] RST_ABSENCE  = 8'd20;

  // Absence counter ceiling
  localparam logic [THR_W-1:0] ABSENCE_MAX = 8'hFF;

  // Configuration bundle
  typedef struct packed {
    logic [THR_W-1:0] down_thr;
    logic [THR_W-1:0] up_thr;
    logic [LVL_W-1:0] max_dist;
    logic [LVL_W-1:0] jump_lim;
    logic [LVL_W-1:0] bottom;
    logic [THR_W-1:0] absence_lim;
  } cfg_t;

  // Result bundle
  typedef struct packed {
    logic [COUNT_W-1:0] count_low;
    logic               rep_done;
  } res_t;

endpackage

// ===== hw/rtl/prc_core.sv =====
// ----------------------------------------------------------------------------
// prc_core: repetition counting state and next-state logic
// Holds phase, count, previous reading, the absence counter and the jump and
// steady flags. Computes the result of the request offered on step_dist and
// commits the new state when step_en is high.
// ----------------------------------------------------------------------------
module prc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [prc_pkg::DIST_W-1:0]  step_dist,
  input  prc_pkg::cfg_t               cfg,
  output prc_pkg::res_t               res
);

  typedef enum logic [1:0] {
    PH_UP     = 2'd0,
    PH_DESC   = 2'd1,
    PH_BOTTOM = 2'd2,
    PH_ASC    = 2'd3
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic [prc_pkg::COUNT_W-1:0]         count_r, count_nxt;
  logic [prc_pkg::LVL_W-1:0]           prev_r, prev_nxt;
  logic [prc_pkg::THR_W-1:0]           absence_r, absence_nxt;
  logic                                jump_r, jump_nxt;
  logic                                steady_r, steady_nxt;
  logic                                done;

  logic [prc_pkg::LVL_W-1:0]           d_clamp;
  logic [prc_pkg::LVL_W-1:0]           d_diff;
  logic [prc_pkg::LVL_W:0]             d_sum;
  logic [prc_pkg::LVL_W-1:0]           d_use;
  logic [prc_pkg::THR_W-1:0]           d_ext;
  logic                                is_jump;
  logic                                skip;

  // Clamp, jump filter and averaging
  always_comb begin
    if (step_dist > {{(prc_pkg::DIST_W-prc_pkg::LVL_W){1'b0}}, cfg.max_dist}) begin
      d_clamp = cfg.max_dist;
    end else begin
      d_clamp = step_dist[prc_pkg::LVL_W-1:0];
    end
    d_diff  = (d_clamp > prev_r) ? (d_clamp - prev_r) : (prev_r - d_clamp);
    is_jump = (prev_r != '0) && (d_diff > cfg.jump_lim);
    d_sum   = {1'b0, d_clamp} + {1'b0, prev_r};
    // second jump in a row: average with the previous stable reading
    d_use   = (is_jump && jump_r) ? d_sum[prc_pkg::LVL_W:1] : d_clamp;
    d_ext   = {{(prc_pkg::THR_W-prc_pkg::LVL_W){1'b0}}, d_use};
  end

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    prev_nxt    = prev_r;
    absence_nxt = absence_r;
    jump_nxt    = jump_r;
    steady_nxt  = steady_r;
    done        = 1'b0;
    skip        = 1'b0;

    if (step_dist == '0) begin
      // no object: count toward absence, fall back to up after a long gap
      if (absence_r != prc_pkg::ABSENCE_MAX) begin
        absence_nxt = absence_r + 1'b1;
      end
      if ((absence_nxt >= cfg.absence_lim) && (phase_r != PH_UP)) begin
        phase_nxt  = PH_UP;
        steady_nxt = 1'b0;
      end
    end else begin
      absence_nxt = '0;
      if (is_jump) begin
        // first jump is dropped, second one is averaged
        jump_nxt = ~jump_r;
        skip     = ~jump_r;
      end else if (prev_r != '0) begin
        jump_nxt = 1'b0;
      end

      if (!skip) begin
        case (phase_r)
          PH_UP: begin
            if (d_ext <= cfg.down_thr) begin
              phase_nxt = PH_DESC;
            end
          end
          PH_DESC: begin
            if ((d_ext <= cfg.down_thr) && (d_use != '0)) begin
              if (d_use <= cfg.bottom) begin
                phase_nxt = PH_BOTTOM;
              end
            end else if (d_ext > cfg.up_thr) begin
              phase_nxt = PH_UP;
            end
          end
          PH_BOTTOM: begin
            if (d_ext >= cfg.up_thr) begin
              phase_nxt  = PH_ASC;
              steady_nxt = 1'b0;
            end
          end
          PH_ASC: begin
            if (d_ext >= cfg.up_thr) begin
              if (d_use == prev_r) begin
                if (steady_r) begin
                  count_nxt  = count_r + 1'b1;
                  done       = 1'b1;
                  phase_nxt  = PH_UP;
                  steady_nxt = 1'b0;
                end else begin
                  steady_nxt = 1'b1;
                end
              end else begin
                steady_nxt = 1'b0;
              end
            end else if (d_ext <= cfg.down_thr) begin
              phase_nxt  = PH_BOTTOM;
              steady_nxt = 1'b0;
            end
          end
          default: begin
            phase_nxt = PH_UP;
          end
        endcase
        prev_nxt = d_use;
      end
    end
  end

  assign res.count_low = count_nxt;
  assign res.rep_done  = done;

  // Commit state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_UP;
      count_r   <= '0;
      prev_r    <= '0;
      absence_r <= '0;
      jump_r    <= 1'b0;
      steady_r  <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      prev_r    <= prev_nxt;
      absence_r <= absence_nxt;
      jump_r    <= jump_nxt;
      steady_r  <= steady_nxt;
    end
  end

endmodule

// ===== hw/rtl/proximity_rep_counter_top.sv =====
// ----------------------------------------------------------------------------
// proximity_rep_counter_top: counts down-and-up repetitions from readings
// Input register, counting core and result register, plus the register file.
// ----------------------------------------------------------------------------
// Throughput: one reading per cycle while out_ready keeps the result register free.
// The input and result registers run as a two-stage pipe under ready/valid.
// Reset (synchronous, rst_n low): phase up, count and counters zero,
// registers to their defaults, both pipe stages empty.
module proximity_rep_counter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [prc_pkg::DIST_W-1:0]     in_distance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [prc_pkg::COUNT_W-1:0]    out_count_low,
  output logic                           out_rep_done,
  input  logic                           cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data
);

  prc_pkg::cfg_t                       cfg_r;
  logic                                s1_valid_r;
  logic [prc_pkg::DIST_W-1:0]          s1_dist_r;
  logic                                out_valid_r;
  prc_pkg::res_t                       out_res_r;
  prc_pkg::res_t                       core_res;
  logic                                advance;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.down_thr    <= prc_pkg::RST_DOWN_THR;
      cfg_r.up_thr      <= prc_pkg::RST_UP_THR;
      cfg_r.max_dist    <= prc_pkg::RST_MAX_DIST;
      cfg_r.jump_lim    <= prc_pkg::RST_JUMP_LIM;
      cfg_r.bottom      <= prc_pkg::RST_BOTTOM;
      cfg_r.absence_lim <= prc_pkg::RST_ABSENCE;
    end else if (cfg_we) begin
      case (cfg_index)
        prc_pkg::REG_DOWN_THR: cfg_r.down_thr    <= cfg_data;
        prc_pkg::REG_UP_THR:   cfg_r.up_thr      <= cfg_data;
        prc_pkg::REG_MAX_DIST: cfg_r.max_dist    <= cfg_data[prc_pkg::LVL_W-1:0];
        prc_pkg::REG_JUMP_LIM: cfg_r.jump_lim    <= cfg_data[prc_pkg::LVL_W-1:0];
        prc_pkg::REG_BOTTOM:   cfg_r.bottom      <= cfg_data[prc_pkg::LVL_W-1:0];
        prc_pkg::REG_ABSENCE:  cfg_r.absence_lim <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance the held request when the result register is free
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dist_r <= in_distance;
    end
  end

  prc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_dist (s1_dist_r),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count_low = out_res_r.count_low;
  assign out_rep_done  = out_res_r.rep_done;

endmodule

// ===== hw/rtl/prc_checker.sv =====
// ----------------------------------------------------------------------------
// prc_checker: port-level checks for the proximity repetition counter
// Tracks the last delivered count and checks count steps, reset and the
// result handshake. Attached to the top level by bind.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [prc_pkg::COUNT_W-1:0]    out_count_low,
  input logic                           out_rep_done
);

  logic [prc_pkg::COUNT_W-1:0] last_count_r;
  logic                        out_fire;

  assign out_fire = out_valid && out_ready;

  // Track the count of the last delivered request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
    end else if (out_fire) begin
      last_count_r <= out_count_low;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_rep_done |-> out_count_low == last_count_r + 1'b1)
    else $error("repetition did not advance the count by one");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_rep_done |-> out_count_low == last_count_r)
    else $error("count changed without a repetition");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count_low)
                                && $stable(out_rep_done))
    else $error("stalled result changed");

endmodule

bind proximity_rep_counter_top prc_checker u_prc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_count_low (out_count_low),
  .out_rep_done  (out_rep_done)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: repetition counting check for proximity_rep_counter_top
// Feeds distance readings through the request handshake while the result side
// stalls on its own pattern. It predicts count and buzzer pulse per reading
// and compares every result in order. Covers directed repetitions, jumps,
// absence, register extremes, long result stalls and randomized sessions.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 9;
  localparam int DRAIN_SLACK      = 4;
  localparam int TAIL_CYCLES      = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SESSIONS         = 5;
  localparam int SESSION_ITEMS    = 120;

  localparam logic [1:0] JUMPS_TO_AVERAGE = 2'd2;
  localparam logic [1:0] STEADY_TO_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    PHASE_UP,
    PHASE_DESC,
    PHASE_BOTTOM,
    PHASE_ASC
  } rep_phase_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [prc_pkg::DIST_W-1:0]     in_distance = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [prc_pkg::COUNT_W-1:0]    out_count_low;
  logic                           out_rep_done;
  logic                           cfg_we      = 1'b0;
  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  proximity_rep_counter_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_distance  (in_distance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_count_low(out_count_low),
    .out_rep_done (out_rep_done),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Register copies used by the counting predictor
  logic [prc_pkg::THR_W-1:0] down_thr    = prc_pkg::RST_DOWN_THR;
  logic [prc_pkg::THR_W-1:0] up_thr      = prc_pkg::RST_UP_THR;
  logic [prc_pkg::LVL_W-1:0] clamp_max   = prc_pkg::RST_MAX_DIST;
  logic [prc_pkg::LVL_W-1:0] jump_lim    = prc_pkg::RST_JUMP_LIM;
  logic [prc_pkg::LVL_W-1:0] bottom_lvl  = prc_pkg::RST_BOTTOM;
  logic [prc_pkg::THR_W-1:0] absence_lim = prc_pkg::RST_ABSENCE;

  // Counter state as seen by the predictor
  rep_phase_t                rep_phase   = PHASE_UP;
  logic [15:0]               rep_total   = '0;
  logic [prc_pkg::LVL_W-1:0] last_level  = '0;
  logic [prc_pkg::THR_W-1:0] zero_run    = '0;
  logic [1:0]                jump_run    = '0;
  logic [1:0]                steady_run  = '0;

  prc_pkg::res_t              expected_counts[$];
  logic [prc_pkg::DIST_W-1:0] pending_readings[$];
  int                         walk_level;
  int                         mismatches    = 0;
  bit                         sender_steady = 1'b0;
  int                         hold_asked    = 0;

  // Work out count and pulse for one accepted reading, then queue them
  function automatic void predict_reading(input logic [prc_pkg::DIST_W-1:0] raw);
    logic [prc_pkg::DIST_W-1:0] d;
    logic                       pulse;
    bit                         skip;
    int                         diff;
    prc_pkg::res_t              want;
    d     = raw;
    pulse = 1'b0;
    skip  = 1'b0;
    if (d == '0) begin
      // Count absence; a long one sends the phase back to up
      if (zero_run != prc_pkg::ABSENCE_MAX) zero_run = zero_run + 1'b1;
      if (zero_run >= absence_lim && rep_phase != PHASE_UP) begin
        rep_phase  = PHASE_UP;
        steady_run = '0;
      end
    end else begin
      zero_run = '0;
      if (d > clamp_max) d = prc_pkg::DIST_W'(clamp_max);
      // Drop the first jump, average the second one with the last level
      if (last_level != '0) begin
        diff = int'(d) - int'(last_level);
        if (diff > int'(jump_lim) || diff < -int'(jump_lim)) begin
          jump_run = jump_run + 1'b1;
          if (jump_run < JUMPS_TO_AVERAGE) skip = 1'b1;
        end else begin
          jump_run = '0;
        end
        if (!skip && jump_run >= JUMPS_TO_AVERAGE) begin
          d        = (d + prc_pkg::DIST_W'(last_level)) >> 1;
          jump_run = '0;
        end
      end
      if (!skip) begin
        case (rep_phase)
          PHASE_UP: begin
            if (d <= down_thr) rep_phase = PHASE_DESC;
          end
          PHASE_DESC: begin
            if (d <= down_thr && d != '0) begin
              if (d <= bottom_lvl) rep_phase = PHASE_BOTTOM;
            end else if (d > up_thr) begin
              rep_phase = PHASE_UP;
            end
          end
          PHASE_BOTTOM: begin
            if (d >= up_thr) begin
              rep_phase  = PHASE_ASC;
              steady_run = '0;
            end
          end
          default: begin
            if (d >= up_thr) begin
              if (d == prc_pkg::DIST_W'(last_level)) begin
                steady_run = steady_run + 1'b1;
                if (steady_run >= STEADY_TO_COUNT) begin
                  rep_total  = rep_total + 1'b1;
                  pulse      = 1'b1;
                  rep_phase  = PHASE_UP;
                  steady_run = '0;
                end
              end else begin
                steady_run = '0;
              end
            end else if (d <= down_thr) begin
              rep_phase  = PHASE_BOTTOM;
              steady_run = '0;
            end
          end
        endcase
        last_level = d[prc_pkg::LVL_W-1:0];
      end
    end
    want.count_low = rep_total[prc_pkg::COUNT_W-1:0];
    want.rep_done  = pulse;
    expected_counts.push_back(want);
  endfunction

  // Offer one request and hold it until it is taken
  task automatic send_reading(input logic [prc_pkg::DIST_W-1:0] reading);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_distance <= reading;
    do @(posedge clk); while (!in_ready);
    predict_reading(reading);
  endtask

  // Drop valid for a number of cycles
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Send every queued reading in bursts with random gaps, with no gaps while sender_steady is set
  task automatic feed_pending();
    int burst_left;
    burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 24);
    while (pending_readings.size() != 0) begin
      send_reading(pending_readings.pop_front());
      burst_left--;
      if (pending_readings.size() == 0) begin
        pause_sender(1);
      end else if (burst_left == 0 && !sender_steady) begin
        pause_sender($urandom_range(1, 10));
        burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 24);
      end
    end
  endtask

  // Wait until every result is back and the pipe has gone quiet
  task automatic settle();
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [prc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      prc_pkg::REG_DOWN_THR: down_thr    = value;
      prc_pkg::REG_UP_THR:   up_thr      = value;
      prc_pkg::REG_MAX_DIST: clamp_max   = value[prc_pkg::LVL_W-1:0];
      prc_pkg::REG_JUMP_LIM: jump_lim    = value[prc_pkg::LVL_W-1:0];
      prc_pkg::REG_BOTTOM:   bottom_lvl  = value[prc_pkg::LVL_W-1:0];
      prc_pkg::REG_ABSENCE:  absence_lim = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input int dn, input int up, input int mx,
                                input int jl, input int bt, input int ab);
    write_reg(prc_pkg::REG_DOWN_THR, prc_pkg::CFG_DATA_W'(dn));
    write_reg(prc_pkg::REG_UP_THR,   prc_pkg::CFG_DATA_W'(up));
    write_reg(prc_pkg::REG_MAX_DIST, prc_pkg::CFG_DATA_W'(mx));
    write_reg(prc_pkg::REG_JUMP_LIM, prc_pkg::CFG_DATA_W'(jl));
    write_reg(prc_pkg::REG_BOTTOM,   prc_pkg::CFG_DATA_W'(bt));
    write_reg(prc_pkg::REG_ABSENCE,  prc_pkg::CFG_DATA_W'(ab));
  endtask

  // Pick a consistent set of thresholds so full repetitions can happen
  task automatic randomize_thresholds();
    int mx, up, dn;
    mx = $urandom_range(24, 63);
    up = $urandom_range(12, mx - 4);
    dn = $urandom_range(4, up - 6);
    write_all_regs(dn, up, mx, $urandom_range(3, 16), $urandom_range(1, dn - 1),
                   $urandom_range(1, 12));
    walk_level = mx;
  endtask

  // Move toward a level in steps that stay within the jump limit
  task automatic walk_to(input int target);
    int step;
    while (walk_level != target) begin
      step = $urandom_range(1, (jump_lim == 0) ? 1 : int'(jump_lim));
      if (walk_level > target)
        walk_level = (walk_level - target > step) ? walk_level - step : target;
      else
        walk_level = (target - walk_level > step) ? walk_level + step : target;
      pending_readings.push_back(prc_pkg::DIST_W'(walk_level));
    end
  endtask

  // Queue a clean down, bottom, up and hold sequence
  task automatic queue_repetition();
    int low, top;
    low = $urandom_range(1, int'(bottom_lvl));
    walk_to(low);
    repeat ($urandom_range(0, 2)) pending_readings.push_back(prc_pkg::DIST_W'(low));
    top = $urandom_range(int'(up_thr), int'(clamp_max));
    walk_to(top);
    repeat ($urandom_range(2, 4)) pending_readings.push_back(prc_pkg::DIST_W'(top));
  endtask

  // Queue spikes, absence runs, raw readings or a half repetition
  task automatic queue_noise();
    case ($urandom_range(0, 4))
      0: pending_readings.push_back(prc_pkg::DIST_W'($urandom_range(1, 1023)));
      1: repeat (2) pending_readings.push_back(prc_pkg::DIST_W'($urandom_range(1, 1023)));
      2: repeat ($urandom_range(1, int'(absence_lim) + 2)) pending_readings.push_back('0);
      3: repeat ($urandom_range(1, 4))
           pending_readings.push_back(prc_pkg::DIST_W'($urandom_range(0, 1023)));
      default: walk_to($urandom_range(int'(down_thr), int'(up_thr)));
    endcase
  endtask

  task automatic queue_mixed(input int count);
    repeat (count) begin
      case ($urandom_range(0, 2))
        0:       pending_readings.push_back('0);
        1:       pending_readings.push_back(prc_pkg::DIST_W'($urandom_range(1, 70)));
        default: pending_readings.push_back(prc_pkg::DIST_W'($urandom_range(0, 1023)));
      endcase
    end
  endtask

  // Full repetitions at reset thresholds, with clamp, jumps and absence
  task automatic test_directed_reps();
    int unsigned rep_seq[15];
    int unsigned absence_seq[7];
    rep_seq = '{1023, 40, 32, 24, 16, 12, 8, 4, 0, 3, 60, 55, 34, 34, 34};
    foreach (rep_seq[i]) pending_readings.push_back(prc_pkg::DIST_W'(rep_seq[i]));
    feed_pending();
    settle();
    write_reg(prc_pkg::REG_ABSENCE, 8'd2);
    absence_seq = '{26, 18, 12, 0, 0, 1, 512};
    foreach (absence_seq[i]) pending_readings.push_back(prc_pkg::DIST_W'(absence_seq[i]));
    feed_pending();
    settle();
  endtask

  // Every register at its extremes, including a saturating absence run
  task automatic test_register_extremes();
    write_all_regs(0, 255, 63, 0, 0, 0);
    queue_mixed(40);
    feed_pending();
    settle();
    write_all_regs(255, 0, 0, 255, 63, 255);
    pending_readings.push_back(prc_pkg::DIST_W'(5));
    repeat (260) pending_readings.push_back('0);
    queue_mixed(20);
    feed_pending();
    settle();
    write_all_regs(1, 1, 1, 1, 1, 1);
    queue_mixed(30);
    feed_pending();
    settle();
  endtask

  // Hold the result side off so the pipe fills and stalls its input
  task automatic test_long_stall();
    randomize_thresholds();
    hold_asked++;
    sender_steady = 1'b1;
    while (pending_readings.size() < 40) queue_repetition();
    feed_pending();
    sender_steady = 1'b0;
    settle();
  endtask

  // Mostly clean repetitions with random content, the rest noise
  task automatic test_random_sessions();
    repeat (SESSIONS) begin
      randomize_thresholds();
      while (pending_readings.size() < SESSION_ITEMS) begin
        if ($urandom_range(0, 3) != 0) queue_repetition();
        else queue_noise();
      end
      feed_pending();
      settle();
    end
  endtask

  // Result side: long hold on request, otherwise a rotating stall pattern
  int          hold_seen   = 0;
  int          hold_left   = 0;
  int          pattern_age = 0;
  logic [15:0] ready_pattern = '1;

  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom);
        endcase
      end
      pattern_age--;
      out_ready     <= ready_pattern[0];
      ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Compare each accepted result with the oldest prediction
  prc_pkg::res_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, actual count_low=%0d rep_done=%0b",
                 $time, out_count_low, out_rep_done);
        mismatches++;
      end else begin
        want_res = expected_counts.pop_front();
        if (out_count_low !== want_res.count_low || out_rep_done !== want_res.rep_done) begin
          $display("%0t: result mismatch, expected count_low=%0d rep_done=%0b,",
                   $time, want_res.count_low, want_res.rep_done);
          $display("%0t:   actual count_low=%0d rep_done=%0b",
                   $time, out_count_low, out_rep_done);
          mismatches++;
        end
      end
    end
  end

  // Stop the run when nothing moves on either side for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_counts.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_reps();
    test_register_extremes();
    test_long_stall();
    test_random_sessions();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/prc_pkg.sv
hw/rtl/prc_core.sv
hw/rtl/proximity_rep_counter_top.sv
hw/rtl/prc_checker.sv
verif/testbench.sv
